>>> src/pmst_pkg.sv
// shared types and constants for the prim minimum spanning tree block
`timescale 1ns / 1ps
package pmst_pkg;
    localparam int VERT_W  = 4;
    localparam int WEIGHT_W = 16;
    localparam int SUM_W   = 20;
    localparam int COUNT_W = 5;

    typedef enum logic [0:0] {
        CMD_WRITE = 1'b0,
        CMD_START = 1'b1
    } cmd_t;

    typedef struct packed {
        logic [0:0]          command;
        logic [VERT_W-1:0]   row;
        logic [VERT_W-1:0]   col;
        logic [WEIGHT_W-1:0] edge_weight;
    } in_beat_t;

    typedef struct packed {
        logic [VERT_W-1:0]   parent;
        logic [VERT_W-1:0]   child;
        logic [WEIGHT_W-1:0] tree_edge_weight;
        logic [SUM_W-1:0]    total_weight;
        logic                last;
        logic                error;
    } out_beat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE2,
        ST_INIT,
        ST_SCAN,
        ST_RELAX,
        ST_EMIT,
        ST_ERROR
    } state_t;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic                init;
        logic                relax;
        logic                pick_valid;
        logic [VERT_W-1:0]   pick;
        logic                shift;
    } cell_ctrl_t;

    // data moving along the chain toward the head
    typedef struct packed {
        logic                valid;
        logic [VERT_W-1:0]   vert;
        logic [WEIGHT_W-1:0] weight;
        logic [VERT_W-1:0]   parent;
    } chain_t;
endpackage

>>> src/pmst_cell.sv
// one vertex cell: best edge, parent, reached flag and its min-scan stage
`timescale 1ns / 1ps
module pmst_cell
    import pmst_pkg::*;
#(
    parameter logic [VERT_W-1:0] VERT = '0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  cell_ctrl_t          ctrl,
    input  logic                in_use,
    input  logic [WEIGHT_W-1:0] row_weight,
    input  chain_t              chain_in,
    output chain_t              chain_out,
    output logic [WEIGHT_W-1:0] best_weight,
    output logic [VERT_W-1:0]   best_parent
);
    logic                reached_reg, reached_next;
    logic [WEIGHT_W-1:0] weight_reg, weight_next;
    logic [VERT_W-1:0]   parent_reg, parent_next;
    chain_t              stage_reg, stage_next;
    logic                cand;

    assign cand = in_use && !reached_reg && (weight_reg != '0);

    always_comb
    begin
        reached_next = reached_reg;
        weight_next  = weight_reg;
        parent_next  = parent_reg;
        if (ctrl.init)
        begin
            reached_next = (VERT == '0);
            weight_next  = in_use ? row_weight : '0;
            parent_next  = '0;
        end
        else if (ctrl.relax && !reached_reg)
        begin
            if (ctrl.pick_valid && ctrl.pick == VERT)
                reached_next = 1'b1;
            else if (in_use && row_weight != '0 &&
                     (weight_reg == '0 || row_weight < weight_reg))
            begin
                weight_next = row_weight;
                parent_next = ctrl.pick;
            end
        end
    end

    // running minimum passes toward vertex one; ties keep the lower vertex
    always_comb
    begin
        stage_next = chain_in;
        if (cand && (!chain_in.valid || weight_reg <= chain_in.weight))
        begin
            stage_next.valid  = 1'b1;
            stage_next.vert   = VERT;
            stage_next.weight = weight_reg;
            stage_next.parent = parent_reg;
        end
        if (ctrl.init)
            stage_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reached_reg <= (VERT == '0);
            weight_reg  <= '0;
            parent_reg  <= '0;
            stage_reg   <= '0;
        end
        else
        begin
            reached_reg <= reached_next;
            weight_reg  <= weight_next;
            parent_reg  <= parent_next;
            if (ctrl.shift || ctrl.init)
                stage_reg <= stage_next;
        end
    end

    assign chain_out   = stage_reg;
    assign best_weight = weight_reg;
    assign best_parent = parent_reg;
endmodule

>>> src/prim_minimum_spanning_tree.sv
// prim minimum spanning tree over a dense weight matrix, chain of vertex cells
`timescale 1ns / 1ps
// A write beat stores one symmetric weight (the entry, then its mirror);
// weight zero means no edge. A start beat runs Prim from vertex zero over the
// first vertex_count vertices (written via cfg_wdata, clamped to
// 2..min(MAX_VERTICES,16)). Each vertex has a cell holding its best edge; one
// matrix row is read per round and relaxes all cells at once, then the minimum
// ripples down the chain of cells, one cell per cycle. A round is a row fetch
// followed by a chain scan; a full-size run's time to its result beats is set
// by the chain length and the single matrix read port. Results follow, one edge
// beat per vertex 1..n-1, the last carrying the total; a disconnected graph
// yields one beat with error set.
// The input is accepted only when the sequencer is idle.
module prim_minimum_spanning_tree
    import pmst_pkg::*;
#(
    parameter int MAX_VERTICES = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  in_beat_t           in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output out_beat_t          out_data,
    input  logic               cfg_we,
    input  logic [COUNT_W-1:0] cfg_wdata
);
    localparam int NV    = (MAX_VERTICES < 16) ? MAX_VERTICES : 16;
    localparam int ADDR_W = 2 * VERT_W;
    localparam int CNT_W  = $clog2(NV + 3);

    // weight memory, one read and one write port
    logic [WEIGHT_W-1:0] mem [0:(1<<ADDR_W)-1];
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr, mem_raddr;
    logic [WEIGHT_W-1:0] mem_wdata;
    logic [WEIGHT_W-1:0] mem_rdata_reg;
    logic [VERT_W-1:0]   rd_row, rd_col;

    state_t              state_reg, state_next;
    logic [COUNT_W-1:0]  count_reg;
    logic [VERT_W-1:0]   n_m1;
    logic [CNT_W-1:0]    step_reg, step_next;
    logic [VERT_W-1:0]   round_reg, round_next;
    logic [VERT_W-1:0]   pick_reg, pick_next;
    logic                pick_valid_reg, pick_valid_next;
    logic [VERT_W-1:0]   emit_reg, emit_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    in_beat_t            hold_reg;
    logic                in_fire, out_fire;

    logic [WEIGHT_W-1:0] row_w [NV];
    logic [WEIGHT_W-1:0] best_w [NV];
    logic [VERT_W-1:0]   best_p [NV];
    chain_t              chain [NV+1];
    cell_ctrl_t          ctrl;

    assign n_m1 = (count_reg < COUNT_W'(2)) ? VERT_W'(1) :
                  (count_reg > COUNT_W'(NV)) ? VERT_W'(NV - 1) :
                  VERT_W'(count_reg - COUNT_W'(1));

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= COUNT_W'(16);
        else if (cfg_we)
            count_reg <= cfg_wdata;
    end

    // the memory read port is indexed by the row being relaxed; each cell
    // reads its own column from a copy of that row latched column by column
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        mem_rdata_reg <= mem[mem_raddr];
    end
    assign mem_raddr = {rd_row, rd_col};

    // row buffer, filled one column per cycle during the fetch sweep
    logic [WEIGHT_W-1:0] rowbuf_reg [NV];
    logic                fetch;
    logic [VERT_W-1:0]   fetch_col_reg;
    always_ff @(posedge clk)
    begin
        if (fetch)
            rowbuf_reg[fetch_col_reg] <= mem_rdata_reg;
    end
    for (genvar g = 0; g < NV; g++)
    begin : g_row
        assign row_w[g] = rowbuf_reg[g];
    end

    // write-port selection: the accepted beat writes (row,col), then ST_WRITE2 writes the mirror
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = {in_data.row, in_data.col};
        mem_wdata = in_data.edge_weight;
        if (in_fire && in_data.command == CMD_WRITE &&
            32'(in_data.row) < NV && 32'(in_data.col) < NV)
            mem_we = 1'b1;
        else if (state_reg == ST_WRITE2)
        begin
            mem_we    = 1'b1;
            mem_waddr = {hold_reg.col, hold_reg.row};
            mem_wdata = hold_reg.edge_weight;
        end
    end

    // sequencer phases: fetch the row of the last pick, apply it, then let the
    // minimum ripple down the chain of cells
    logic [CNT_W-1:0] phase_len;
    assign phase_len = CNT_W'(NV + 1);

    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        round_next      = round_reg;
        pick_next       = pick_reg;
        pick_valid_next = pick_valid_reg;
        emit_next       = emit_reg;
        sum_next        = sum_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && in_data.command == CMD_WRITE)
                    state_next = ST_WRITE2;
                else if (in_fire)
                begin
                    state_next = ST_INIT;
                    step_next  = '0;
                    pick_next  = '0;
                    pick_valid_next = 1'b0;
                    round_next = VERT_W'(1);
                end
            end
            ST_WRITE2: state_next = ST_IDLE;
            ST_INIT:
            begin
                // fetch row 0, then init the cells from it
                step_next = step_reg + CNT_W'(1);
                if (step_reg == phase_len)
                begin
                    state_next = ST_SCAN;
                    step_next  = '0;
                end
            end
            ST_SCAN:
            begin
                step_next = step_reg + CNT_W'(1);
                if (step_reg == CNT_W'(NV - 1))
                begin
                    step_next = '0;
                    if (!chain[1].valid)
                        state_next = ST_ERROR;
                    else
                    begin
                        pick_next       = chain[1].vert;
                        pick_valid_next = 1'b1;
                        state_next      = ST_RELAX;
                    end
                end
            end
            ST_RELAX:
            begin
                step_next = step_reg + CNT_W'(1);
                if (step_reg == phase_len)
                begin
                    step_next = '0;
                    if (round_reg == n_m1)
                    begin
                        state_next = ST_EMIT;
                        emit_next  = VERT_W'(1);
                        sum_next   = '0;
                    end
                    else
                    begin
                        round_next = round_reg + VERT_W'(1);
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_fire)
                begin
                    sum_next  = sum_reg + SUM_W'(best_w[emit_reg]);
                    emit_next = emit_reg + VERT_W'(1);
                    if (emit_reg == n_m1)
                        state_next = ST_IDLE;
                end
            end
            ST_ERROR:
            begin
                if (out_fire)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // fetch sweep: step k reads column k, its data lands in the read register in the next cycle
    always_comb
    begin
        rd_row = pick_reg;
        rd_col = VERT_W'(step_reg);
        fetch  = 1'b0;
        ctrl   = '0;
        ctrl.pick       = pick_reg;
        ctrl.pick_valid = pick_valid_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                rd_row = '0;
                fetch  = (step_reg >= CNT_W'(1)) && (step_reg <= CNT_W'(NV));
                ctrl.init = (step_reg == phase_len);
            end
            ST_RELAX:
            begin
                fetch      = (step_reg >= CNT_W'(1)) && (step_reg <= CNT_W'(NV));
                ctrl.relax = (step_reg == phase_len);
            end
            ST_SCAN: ctrl.shift = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= '0;
            round_reg      <= '0;
            pick_reg       <= '0;
            pick_valid_reg <= 1'b0;
            emit_reg       <= '0;
            sum_reg        <= '0;
            fetch_col_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            round_reg      <= round_next;
            pick_reg       <= pick_next;
            pick_valid_reg <= pick_valid_next;
            emit_reg       <= emit_next;
            sum_reg        <= sum_next;
            // column whose read data shows up next cycle
            fetch_col_reg  <= VERT_W'(step_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            hold_reg <= in_data;
    end

    // chain of vertex cells; the tail feeds an empty beat
    assign chain[NV] = '0;
    for (genvar g = 0; g < NV; g++)
    begin : g_cell
        logic in_use;
        assign in_use = (g != 0) && (VERT_W'(g) <= n_m1);
        pmst_cell #(.VERT(VERT_W'(g))) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .in_use     (in_use),
            .row_weight (row_w[g]),
            .chain_in   (chain[g+1]),
            .chain_out  (chain[g]),
            .best_weight(best_w[g]),
            .best_parent(best_p[g])
        );
    end

    // result beat
    logic [SUM_W-1:0] sum_total;
    assign sum_total = sum_reg + SUM_W'(best_w[emit_reg]);
    assign out_valid = (state_reg == ST_EMIT) || (state_reg == ST_ERROR);
    always_comb
    begin
        out_data = '0;
        if (state_reg == ST_ERROR)
            out_data.error = 1'b1;
        else
        begin
            out_data.parent           = best_p[emit_reg];
            out_data.child            = emit_reg;
            out_data.tree_edge_weight = best_w[emit_reg];
            out_data.last             = (emit_reg == n_m1);
            out_data.total_weight     = (emit_reg == n_m1) ? sum_total : '0;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_ready)
        else $error("input accepted while busy");
    a_error_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.error) |-> (!out_data.last && out_data.total_weight == '0))
        else $error("error beat carries data");
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("result beat changed while stalled");
`endif
endmodule
